/* hdl/slpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_pkg: shared types and constants
// Mode codes, colour and coefficient constants, and the words passed
// between the status LED pattern sequencer and the top level.
// ----------------------------------------------------------------------------
package slpg_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 1024;

	localparam int MODE_W = 3;
	localparam int PHASE_W = 12;
	localparam int MS_W = 10;
	localparam int CHAN_W = 8;
	localparam int MUL_W = 25;
	localparam int ENV_W = 17;

	localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
	localparam logic [MODE_W-1:0] MODE_BOOTING  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_PRESENCE = 3'd3;
	localparam logic [MODE_W-1:0] MODE_ERROR    = 3'd4;
	localparam logic [MODE_W-1:0] MODE_TEST_OK  = 3'd5;
	localparam logic [MODE_W-1:0] MODE_TEST_FAIL = 3'd6;
	localparam logic [MODE_W-1:0] MODE_WIFI_OFF = 3'd7;

	localparam logic [PHASE_W:0] PHASE_WRAP = 13'd4000;
	localparam logic [PHASE_W-1:0] HALF_WRAP = 12'd2000;

	// floor(n / 4000) = (n * DIV4000_RECIP) >> 36 for n < 2^24
	localparam logic [MUL_W-1:0] DIV4000_RECIP = 25'd17179870;
	localparam int DIV4000_SHIFT = 36;
	// floor(ph / 125) = (ph * DIV125_RECIP) >> 20 for ph < 4000
	localparam logic [MUL_W-1:0] DIV125_RECIP = 25'd8389;

	// sine envelope, Q28 angle
	localparam longint TWO_PI_Q28 = 64'sd1686629713;
	localparam longint ONE_Q28 = 64'sd268435456;

	// brightness = base + (amp * p) >> 16
	localparam logic [15:0] IDLE_BASE = 16'd16384;
	localparam logic [14:0] IDLE_AMP  = 15'd16384;
	localparam logic [15:0] PRES_BASE = 16'd26214;
	localparam logic [14:0] PRES_AMP  = 15'd19661;

	// hue coefficients, Q1.16
	localparam logic [16:0] IDLE_CR = 17'd65536;
	localparam logic [16:0] IDLE_CG = 17'd53084;
	localparam logic [16:0] IDLE_CB = 17'd3277;
	localparam logic [16:0] PRES_CR = 17'd3277;
	localparam logic [16:0] PRES_CG = 17'd24030;
	localparam logic [16:0] PRES_CB = 17'd65536;

	localparam logic [CHAN_W-1:0] BOOT_RED   = 8'd200;
	localparam logic [CHAN_W-1:0] BOOT_GREEN = 8'd80;
	localparam logic [CHAN_W-1:0] OK_GREEN   = 8'd200;
	localparam logic [CHAN_W-1:0] ERR_RED    = 8'd200;
	localparam logic [CHAN_W-1:0] FAIL_RED   = 8'd220;
	localparam logic [CHAN_W-1:0] WIFI_RED   = 8'd216;
	localparam logic [CHAN_W-1:0] WIFI_GREEN = 8'd173;

	typedef struct packed {
		logic                valid;
		logic [MODE_W-1:0]   mode;
		logic [PHASE_W-1:0]  phase;
	} slpg_job_t;

	typedef struct packed {
		logic                valid;
		logic [CHAN_W-1:0]   blue;
		logic [CHAN_W-1:0]   green;
		logic [CHAN_W-1:0]   red;
	} slpg_rgb_t;

endpackage

/* hdl/slpg_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_mul: shared registered multiplier
// One unsigned multiply per cycle while en is high, product registered,
// used for every scaling step of the pattern sequencer.
// ----------------------------------------------------------------------------
module slpg_mul (
	input  logic                            clk,
	input  logic                            en,
	input  logic [slpg_pkg::MUL_W-1:0]      a,
	input  logic [slpg_pkg::MUL_W-1:0]      b,
	output logic [2*slpg_pkg::MUL_W-1:0]    prod_q
);
	import slpg_pkg::*;

	always_ff @(posedge clk) begin
		if (en) begin
			prod_q <= a * b;
		end
	end

endmodule

/* hdl/slpg_env_rom.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_env_rom: sine envelope table
// 0.5 + 0.5*sin(2*pi*k/depth) in Q1.16, built at elaboration from an
// eleven-term series, read with a registered output.
// ----------------------------------------------------------------------------
module slpg_env_rom #(
	parameter int SINE_TABLE_DEPTH = slpg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                                 clk,
	input  logic [$clog2(SINE_TABLE_DEPTH)-1:0]  addr,
	output logic [slpg_pkg::ENV_W-1:0]           data_q
);
	import slpg_pkg::*;

	function automatic logic [ENV_W-1:0] env_at(input int unsigned idx);
		longint m;
		longint ax;
		longint x2;
		longint term;
		longint s;
		logic   neg;
		m = longint'(idx);
		neg = 1'b0;
		if (m * 2 > SINE_TABLE_DEPTH) begin
			m = SINE_TABLE_DEPTH - m;
			neg = 1'b1;
		end
		ax = (m * TWO_PI_Q28) / SINE_TABLE_DEPTH;
		x2 = (ax * ax) >> 28;
		term = ax;
		s = ax;
		term = ((term * x2) >> 28) / 6;   s = s - term;
		term = ((term * x2) >> 28) / 20;  s = s + term;
		term = ((term * x2) >> 28) / 42;  s = s - term;
		term = ((term * x2) >> 28) / 72;  s = s + term;
		term = ((term * x2) >> 28) / 110; s = s - term;
		term = ((term * x2) >> 28) / 156; s = s + term;
		term = ((term * x2) >> 28) / 210; s = s - term;
		term = ((term * x2) >> 28) / 272; s = s + term;
		term = ((term * x2) >> 28) / 342; s = s - term;
		term = ((term * x2) >> 28) / 420; s = s + term;
		if (s > ONE_Q28) begin
			s = ONE_Q28;
		end
		if (s < -ONE_Q28) begin
			s = -ONE_Q28;
		end
		if (neg) begin
			s = -s;
		end
		return ENV_W'((s + ONE_Q28) >> 13);
	endfunction

	logic [ENV_W-1:0] tbl [SINE_TABLE_DEPTH];

	for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_tbl
		assign tbl[i] = env_at(i);
	end

	always_ff @(posedge clk) begin
		data_q <= tbl[addr];
	end

endmodule

/* hdl/slpg_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slpg_core: colour sequencer
// Steps one tick through the shared multiplier: table index, envelope,
// brightness and three channel scalings, or a blink decision; solid modes skip it.
// ----------------------------------------------------------------------------
module slpg_core #(
	parameter int SINE_TABLE_DEPTH = slpg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  slpg_pkg::slpg_job_t    job,
	output logic                   idle,
	output slpg_pkg::slpg_rgb_t    res,
	input  logic                   res_take
);
	import slpg_pkg::*;

	localparam int AW = $clog2(SINE_TABLE_DEPTH);
	localparam int PW = 2 * MUL_W;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_K    = 4'd1;
	localparam logic [3:0] ST_ADDR = 4'd2;
	localparam logic [3:0] ST_ENV  = 4'd3;
	localparam logic [3:0] ST_CR   = 4'd4;
	localparam logic [3:0] ST_CG   = 4'd5;
	localparam logic [3:0] ST_CB   = 4'd6;
	localparam logic [3:0] ST_CBF  = 4'd7;
	localparam logic [3:0] ST_BLK  = 4'd8;
	localparam logic [3:0] ST_DONE = 4'd9;

	logic [3:0]         state_q;
	logic [MODE_W-1:0]  mode_q;
	logic [15:0]        v_q;
	logic [CHAN_W-1:0]  red_q;
	logic [CHAN_W-1:0]  green_q;
	logic [CHAN_W-1:0]  blue_q;

	logic               mul_en;
	logic [MUL_W-1:0]   mul_a;
	logic [MUL_W-1:0]   mul_b;
	logic [PW-1:0]      prod_q;
	logic [ENV_W-1:0]   env_q;
	logic [AW-1:0]      rom_addr;

	logic               pres;
	logic [PHASE_W-1:0] ph_half;
	logic [PHASE_W-1:0] x_pres;
	logic [15:0]        v_now;
	logic [16:0]        coef_r;
	logic [16:0]        coef_g;
	logic [16:0]        coef_b;
	logic [CHAN_W-1:0]  chan_now;
	logic [39:0]        chan_prod;
	logic [4:0]         blink_d;

	slpg_mul u_mul (
		.clk    (clk),
		.en     (mul_en),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	slpg_env_rom #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_rom (
		.clk    (clk),
		.addr   (rom_addr),
		.data_q (env_q)
	);

	// quotient of N / 4000 is below the depth, so the low bits suffice
	assign rom_addr = prod_q[DIV4000_SHIFT +: AW];

	assign pres    = (mode_q == MODE_PRESENCE);
	assign ph_half = (job.phase >= HALF_WRAP) ? (job.phase - HALF_WRAP) : job.phase;
	// (ph mod 2000) * D / 2000 == (2 * (ph mod 2000)) * D / 4000
	assign x_pres  = {ph_half[PHASE_W-2:0], 1'b0};

	assign v_now  = (pres ? PRES_BASE : IDLE_BASE) + {1'b0, prod_q[30:16]};
	assign coef_r = pres ? PRES_CR : IDLE_CR;
	assign coef_g = pres ? PRES_CG : IDLE_CG;
	assign coef_b = pres ? PRES_CB : IDLE_CB;

	// (y * 255) >> 32 as a shift and subtract
	assign chan_prod = {prod_q[31:0], 8'd0} - {8'd0, prod_q[31:0]};
	assign chan_now  = chan_prod[39:32];

	assign blink_d = prod_q[24:20];

	always_comb begin
		mul_en = 1'b1;
		mul_a  = '0;
		mul_b  = '0;
		unique case (state_q)
			ST_IDLE: begin
				mul_en = job.valid;
				if (job.mode == MODE_IDLE) begin
					mul_a = MUL_W'(job.phase);
					mul_b = MUL_W'(SINE_TABLE_DEPTH);
				end else if (job.mode == MODE_PRESENCE) begin
					mul_a = MUL_W'(x_pres);
					mul_b = MUL_W'(SINE_TABLE_DEPTH);
				end else begin
					mul_a = MUL_W'(job.phase);
					mul_b = DIV125_RECIP;
				end
			end
			ST_K: begin
				mul_a = {1'b0, prod_q[23:0]};
				mul_b = DIV4000_RECIP;
			end
			ST_ENV: begin
				mul_a = MUL_W'(pres ? PRES_AMP : IDLE_AMP);
				mul_b = MUL_W'(env_q);
			end
			ST_CR: begin
				mul_a = MUL_W'(v_now);
				mul_b = MUL_W'(coef_r);
			end
			ST_CG: begin
				mul_a = MUL_W'(v_q);
				mul_b = MUL_W'(coef_g);
			end
			ST_CB: begin
				mul_a = MUL_W'(v_q);
				mul_b = MUL_W'(coef_b);
			end
			default: begin
				mul_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (job.valid) begin
						unique case (job.mode)
							MODE_OFF, MODE_BOOTING, MODE_TEST_OK: state_q <= ST_DONE;
							MODE_IDLE, MODE_PRESENCE:             state_q <= ST_K;
							MODE_ERROR, MODE_TEST_FAIL, MODE_WIFI_OFF: state_q <= ST_BLK;
						endcase
					end
				end
				ST_K:    state_q <= ST_ADDR;
				ST_ADDR: state_q <= ST_ENV;
				ST_ENV:  state_q <= ST_CR;
				ST_CR:   state_q <= ST_CG;
				ST_CG:   state_q <= ST_CB;
				ST_CB:   state_q <= ST_CBF;
				ST_CBF:  state_q <= ST_DONE;
				ST_BLK:  state_q <= ST_DONE;
				ST_DONE: begin
					if (res_take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (job.valid) begin
					mode_q  <= job.mode;
					red_q   <= '0;
					green_q <= '0;
					blue_q  <= '0;
					if (job.mode == MODE_BOOTING) begin
						red_q   <= BOOT_RED;
						green_q <= BOOT_GREEN;
					end else if (job.mode == MODE_TEST_OK) begin
						green_q <= OK_GREEN;
					end
				end
			end
			ST_CR: v_q <= v_now;
			ST_CG: red_q <= chan_now;
			ST_CB: green_q <= chan_now;
			ST_CBF: blue_q <= chan_now;
			ST_BLK: begin
				// lit in the even half-periods of the blink
				if (mode_q == MODE_ERROR && !blink_d[2]) begin
					red_q <= ERR_RED;
				end else if (mode_q == MODE_TEST_FAIL && !blink_d[0]) begin
					red_q <= FAIL_RED;
				end else if (mode_q == MODE_WIFI_OFF && !blink_d[0]) begin
					red_q   <= WIFI_RED;
					green_q <= WIFI_GREEN;
				end
			end
			default: begin
			end
		endcase
	end

	assign idle      = (state_q == ST_IDLE);
	assign res.valid = (state_q == ST_DONE);
	assign res.red   = red_q;
	assign res.green = green_q;
	assign res.blue  = blue_q;

endmodule

/* hdl/status_led_pattern_generator.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// status_led_pattern_generator: status LED colour generator
// Mode register, phase counter, tick input and colour output register.
// ----------------------------------------------------------------------------
// Each tick word carries the milliseconds since the last tick; the phase
// (modulo 4000 ms) advances on acceptance and one RGB word follows. Solid
// modes set their colour on acceptance, blinking modes take a blink step,
// and the two breathing modes run through the single shared multiplier that
// computes the table index, the envelope scaling and each colour channel in
// turn; the sine envelope table is a ROM built at elaboration. The tick input
// is ready again once the colour has moved to the output register. Writing a
// mode different from the current one restarts the phase at zero.
module status_led_pattern_generator #(
	parameter int SINE_TABLE_DEPTH = slpg_pkg::SINE_TABLE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data,          // led_mode
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,      // [9:0] elapsed_ms
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata       // [7:0] red, [15:8] green, [23:16] blue
);
	import slpg_pkg::*;

	logic [MODE_W-1:0]  mode_q;
	logic [PHASE_W-1:0] phase_q;
	logic               out_v_q;
	logic [23:0]        out_data_q;

	logic               core_idle;
	logic               in_acc;
	logic [PHASE_W:0]   ph_sum;
	logic [PHASE_W-1:0] ph_next;
	logic               res_take;
	slpg_job_t          job;
	slpg_rgb_t          res;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = core_idle;
	assign in_acc        = s_axis_tvalid && core_idle;

	assign ph_sum  = {1'b0, phase_q} + {3'd0, s_axis_tdata[MS_W-1:0]};
	assign ph_next = (ph_sum >= PHASE_WRAP) ? PHASE_W'(ph_sum - PHASE_WRAP)
	                                        : ph_sum[PHASE_W-1:0];

	assign job.valid = in_acc;
	assign job.mode  = mode_q;
	assign job.phase = ph_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_BOOTING;
			phase_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_data != mode_q) begin
				phase_q <= '0;
			end
			mode_q <= cfg_data;
		end else if (in_acc) begin
			phase_q <= ph_next;
		end
	end

	slpg_core #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
	) u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.job      (job),
		.idle     (core_idle),
		.res      (res),
		.res_take (res_take)
	);

	// output word register; refills in the cycle it is emptied
	assign res_take = res.valid && (!out_v_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_take) begin
			out_v_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_data_q <= {res.blue, res.green, res.red};
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_data_q;

endmodule

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: status LED pattern generator testbench
// Drives tick words and mode writes. A local colour predictor, fed at each
// tick acceptance, queues the expected RGB word, and a monitor checks every
// output word against the oldest entry. Both stream sides idle at random,
// with one long output hold-off that backs up the tick input.
// ----------------------------------------------------------------------------
module tb;
	import slpg_pkg::*;

	localparam int TB_DEPTH = SINE_TABLE_DEPTH_DEF;
	localparam int WRAP_MS = 4000;
	localparam longint unsigned ANGLE_2PI = 64'd1686629713;
	localparam longint UNITY_Q28 = 64'sd268435456;
	localparam int SETTLE_CYCLES = 20;
	localparam int HOLD_CYCLES = 250;
	localparam int CYCLE_LIMIT = 250000;

	typedef struct packed {
		logic [CHAN_W-1:0] blue;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] red;
	} colour_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;

	colour_t colour_q[$];
	logic [MODE_W-1:0] model_mode;
	int unsigned model_phase;
	int errors;
	int cycles;
	bit quiet;
	bit hold_req;

	status_led_pattern_generator dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// colour predictor
	// ------------------------------------------------------------------

	// 0.5 + 0.5*sin(2*pi*k/depth) in Q1.16, Taylor series in Q28
	function automatic int unsigned sine_env(input int unsigned k);
		longint unsigned m, ax, x2, term, dv;
		longint s;
		bit neg;
		m = k % TB_DEPTH;
		neg = 1'b0;
		if (m * 2 > TB_DEPTH) begin
			m = TB_DEPTH - m;
			neg = 1'b1;
		end
		ax = (m * ANGLE_2PI) / TB_DEPTH;
		x2 = (ax * ax) >> 28;
		term = ax;
		s = longint'(ax);
		for (int n = 1; n <= 10; n++) begin
			dv = longint'(2 * n) * longint'(2 * n + 1);
			term = ((term * x2) >> 28) / dv;
			if (n % 2 == 1)
				s = s - longint'(term);
			else
				s = s + longint'(term);
		end
		if (s > UNITY_Q28) s = UNITY_Q28;
		if (s < -UNITY_Q28) s = -UNITY_Q28;
		if (neg) s = -s;
		return 32'(unsigned'(s + UNITY_Q28) >> 13);
	endfunction

	function automatic logic [CHAN_W-1:0] chan_level(input longint unsigned v,
			input longint unsigned c);
		longint unsigned prod;
		prod = v * c * 64'd255;
		return prod[39:32];
	endfunction

	function automatic colour_t colour_for(input logic [MODE_W-1:0] mode,
			input int unsigned ph);
		colour_t col;
		longint unsigned p, v;
		col = '0;
		case (mode)
			MODE_BOOTING: begin
				col.red = 8'd200;
				col.green = 8'd80;
			end
			MODE_IDLE: begin
				p = sine_env((ph * TB_DEPTH) / WRAP_MS);
				v = 16384 + ((16384 * p) >> 16);
				col.red = chan_level(v, 65536);
				col.green = chan_level(v, 53084);
				col.blue = chan_level(v, 3277);
			end
			MODE_PRESENCE: begin
				p = sine_env(((ph % 2000) * TB_DEPTH) / 2000);
				v = 26214 + ((19661 * p) >> 16);
				col.red = chan_level(v, 3277);
				col.green = chan_level(v, 24030);
				col.blue = chan_level(v, 65536);
			end
			MODE_ERROR: begin
				if ((ph / 500) % 2 == 0) col.red = 8'd200;
			end
			MODE_TEST_OK: begin
				col.green = 8'd200;
			end
			MODE_TEST_FAIL: begin
				if ((ph / 125) % 2 == 0) col.red = 8'd220;
			end
			MODE_WIFI_OFF: begin
				if ((ph / 125) % 2 == 0) begin
					col.red = 8'd216;
					col.green = 8'd173;
				end
			end
			default: col = '0;
		endcase
		return col;
	endfunction

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	task automatic send_tick(input logic [MS_W-1:0] ms);
		if (!quiet && $urandom_range(99) < 36) begin
			s_axis_tvalid = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {6'd0, ms};
		do @(posedge clk); while (!s_axis_tready);
		// phase moves on acceptance, then the colour is taken
		model_phase = model_phase + ms;
		if (model_phase >= WRAP_MS) model_phase = model_phase - WRAP_MS;
		colour_q.push_back(colour_for(model_mode, model_phase));
		@(negedge clk);
	endtask

	// stop offering ticks and let every outstanding word drain
	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		while (colour_q.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_mode(input logic [MODE_W-1:0] mode);
		wait_idle();
		cfg_valid = 1'b1;
		cfg_data = mode;
		do @(posedge clk); while (!cfg_ready);
		if (mode != model_mode) model_phase = 0;
		model_mode = mode;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	function automatic logic [MS_W-1:0] pick_elapsed();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 8) return '0;
		if (r < 16) return 10'd1023;
		if (r < 22) return 10'd1000;
		if (r < 40) return MS_W'($urandom_range(130));
		return MS_W'($urandom_range(1023));
	endfunction

	// ------------------------------------------------------------------
	// output side: random ready, long hold-off on request
	// ------------------------------------------------------------------
	initial begin : sink
		int hold_left;
		hold_left = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else if (!quiet && $urandom_range(99) < 36) begin
				m_axis_tready = 1'b0;
			end else begin
				m_axis_tready = 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_colour
		colour_t want, got;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = colour_t'(m_axis_tdata);
			if (colour_q.size() == 0) begin
				if (errors < 10)
					$display("unexpected word r=%0d g=%0d b=%0d", got.red, got.green,
						got.blue);
				errors++;
			end else begin
				want = colour_q.pop_front();
				if (got.red !== want.red || got.green !== want.green
						|| got.blue !== want.blue) begin
					if (errors < 10)
						$display("colour mismatch: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
							want.red, want.green, want.blue, got.red, got.green, got.blue);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_booting_default();
		send_tick(10'd0);
		send_tick(10'd1023);
		send_tick(10'd1000);
	endtask

	task automatic test_solid_modes();
		write_mode(MODE_OFF);
		send_tick(10'd1000);
		send_tick(10'd1023);
		write_mode(MODE_TEST_OK);
		send_tick(10'd7);
	endtask

	// lit and dark edges of each blink
	task automatic test_blink_edges();
		write_mode(MODE_ERROR);
		send_tick(10'd499);
		send_tick(10'd1);
		send_tick(10'd500);
		write_mode(MODE_TEST_FAIL);
		send_tick(10'd124);
		send_tick(10'd1);
		send_tick(10'd125);
		write_mode(MODE_WIFI_OFF);
		send_tick(10'd0);
		send_tick(10'd125);
		send_tick(10'd1023);
	endtask

	task automatic test_breath_wrap();
		write_mode(MODE_IDLE);
		send_tick(10'd1000);
		send_tick(10'd1000);
		send_tick(10'd1000);
		send_tick(10'd999);
		send_tick(10'd1);
		write_mode(MODE_PRESENCE);
		send_tick(10'd500);
		send_tick(10'd1023);
		send_tick(10'd477);
		// same mode again: phase carries on
		write_mode(MODE_PRESENCE);
		send_tick(10'd0);
		send_tick(10'd250);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < 20; ph++) begin
			quiet = (ph >= 8 && ph < 12);
			write_mode(MODE_W'($urandom_range(7)));
			for (int i = 0; i < 47; i++) send_tick(pick_elapsed());
		end
		quiet = 1'b0;
	endtask

	task automatic test_output_stall();
		write_mode(MODE_IDLE);
		hold_req = 1'b1;
		for (int i = 0; i < 80; i++) send_tick(pick_elapsed());
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		quiet = 1'b0;
		hold_req = 1'b0;
		errors = 0;
		cycles = 0;
		model_mode = MODE_BOOTING;
		model_phase = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(negedge clk);

		test_booting_default();
		test_solid_modes();
		test_blink_edges();
		test_breath_wrap();
		test_random_phases();
		test_output_stall();

		wait_idle();
		if (errors == 0 && colour_q.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
